@@ src/dfu_req_pkg.sv @@
// Shared types, codes and constants for the DFU request engine.
// No dependencies; every other file uses this package by scoped names.
package dfu_req_pkg;

  localparam int TRANSFER_SIZE_DEF = 1024;

  // Request modes.
  localparam logic [2:0] MODE_DETACH    = 3'd0;
  localparam logic [2:0] MODE_DOWNLOAD  = 3'd1;
  localparam logic [2:0] MODE_UPLOAD    = 3'd2;
  localparam logic [2:0] MODE_GETSTATUS = 3'd3;
  localparam logic [2:0] MODE_CLRSTATUS = 3'd4;
  localparam logic [2:0] MODE_GETSTATE  = 3'd5;
  localparam logic [2:0] MODE_ABORT     = 3'd6;
  localparam logic [2:0] MODE_OTHER     = 3'd7;

  // Result kinds.
  localparam logic [3:0] KIND_STATUS    = 4'd0;
  localparam logic [3:0] KIND_STATE     = 4'd1;
  localparam logic [3:0] KIND_CMD_LIST  = 4'd2;
  localparam logic [3:0] KIND_ERASE     = 4'd3;
  localparam logic [3:0] KIND_PROGRAM   = 4'd4;
  localparam logic [3:0] KIND_READ      = 4'd5;
  localparam logic [3:0] KIND_ACK       = 4'd6;
  localparam logic [3:0] KIND_UNHANDLED = 4'd7;
  localparam logic [3:0] KIND_RESET     = 4'd8;

  // Block-zero commands and fixed reply values.
  localparam logic [7:0]  CMD_SET_ADDRESS = 8'h21;
  localparam logic [7:0]  CMD_ERASE_PAGE  = 8'h41;
  localparam logic [23:0] BUSY_POLL_MS    = 24'd100;
  localparam logic [7:0]  STATUS_ERROR    = 8'd10;
  localparam logic [10:0] LEN_STATUS      = 11'd6;
  localparam logic [10:0] LEN_STATE       = 11'd1;
  localparam logic [10:0] LEN_CMD_LIST    = 11'd3;

  // DFU state numbers as reported on the wire.
  localparam logic [3:0] CODE_IDLE     = 4'd2;
  localparam logic [3:0] CODE_DN_SYNC  = 4'd3;
  localparam logic [3:0] CODE_DN_BUSY  = 4'd4;
  localparam logic [3:0] CODE_DN_IDLE  = 4'd5;
  localparam logic [3:0] CODE_MAN_SYNC = 4'd6;
  localparam logic [3:0] CODE_MANIFEST = 4'd7;
  localparam logic [3:0] CODE_UP_IDLE  = 4'd9;
  localparam logic [3:0] CODE_ERROR    = 4'd10;

  // Configuration register indexes and reset values.
  localparam logic [1:0]  CFG_APP_START   = 2'd0;
  localparam logic [1:0]  CFG_FLASH_END   = 2'd1;
  localparam logic [1:0]  CFG_UPLOAD_EN   = 2'd2;
  localparam logic [31:0] APP_START_RESET = 32'h0800_2000;
  localparam logic [31:0] FLASH_END_RESET = 32'h0801_0000;

  // Download-busy only exists inside a status request, so it has no
  // stored state of its own.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DN_SYNC  = 7'b0000010,
    ST_DN_IDLE  = 7'b0000100,
    ST_MAN_SYNC = 7'b0001000,
    ST_MANIFEST = 7'b0010000,
    ST_UP_IDLE  = 7'b0100000,
    ST_ERROR    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] block_number;
    logic [15:0] transfer_length;
    logic [7:0]  command_byte;
    logic [31:0] payload_word;
  } req_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [10:0] reply_length;
    logic [7:0]  status_code;
    logic [23:0] poll_timeout;
    logic [3:0]  state_code;
    logic [31:0] flash_address;
    logic [10:0] flash_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] app_start_address;
    logic [31:0] flash_end_address;
    logic        upload_enable;
  } cfg_t;

  // Handshake between the request core and the result buffer.
  typedef struct packed {
    logic commit;
    logic has_second;
  } buf_ctl_t;

  function automatic logic [3:0] state_code(state_t s);
    logic [3:0] c;
    case (s)
      ST_IDLE:     c = CODE_IDLE;
      ST_DN_SYNC:  c = CODE_DN_SYNC;
      ST_DN_IDLE:  c = CODE_DN_IDLE;
      ST_MAN_SYNC: c = CODE_MAN_SYNC;
      ST_MANIFEST: c = CODE_MANIFEST;
      ST_UP_IDLE:  c = CODE_UP_IDLE;
      ST_ERROR:    c = CODE_ERROR;
      default:     c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ src/dfu_req_core.sv @@
// Request decode, DFU state, latched download and address pointer.
// Depends on dfu_req_pkg. Results are formed combinationally from the
// registered request; state is updated when the request commits.
module dfu_req_core #(
  parameter int TRANSFER_SIZE = dfu_req_pkg::TRANSFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dfu_req_pkg::req_t    req,
  input  logic                 commit,
  input  dfu_req_pkg::cfg_t    cfg,
  output dfu_req_pkg::result_t res0,
  output dfu_req_pkg::result_t res1,
  output logic                 has_second
);

  localparam int LEN_W = $clog2(TRANSFER_SIZE + 1);
  localparam logic [LEN_W-1:0] TS_LEN = LEN_W'(TRANSFER_SIZE);
  localparam logic [31:0]      TS_32  = 32'(TRANSFER_SIZE);
  localparam logic [10:0]      TS_11  = 11'(TRANSFER_SIZE);

  dfu_req_pkg::state_t state, state_next;
  logic [15:0]      latched_block, latched_block_next;
  logic [LEN_W-1:0] latched_length, latched_length_next;
  logic [7:0]       latched_command, latched_command_next;
  logic [31:0]      latched_word, latched_word_next;
  logic [31:0]      addr_ptr, addr_ptr_next;

  logic [15:0]      blk_sel;
  logic [31:0]      blk_off;
  logic [31:0]      base;
  logic             use_word;
  logic [31:0]      chk_base, chk_len, chk_top;
  logic             in_range;
  logic [LEN_W-1:0] len_clamp;
  logic             flash_second;

  // One address generator and one range check serve both upload reads
  // and the deferred download actions.
  assign blk_sel  = (req.mode == dfu_req_pkg::MODE_UPLOAD) ? req.block_number : latched_block;
  assign blk_off  = 32'(blk_sel) - 32'd2;
  assign base     = addr_ptr + 32'(blk_off * TS_32);
  assign use_word = (req.mode != dfu_req_pkg::MODE_UPLOAD) && (latched_block == 16'd0);
  assign chk_base = use_word ? latched_word : base;
  assign chk_len  = ((req.mode == dfu_req_pkg::MODE_UPLOAD) || (latched_block == 16'd0))
                    ? TS_32 : 32'(latched_length);
  assign chk_top  = chk_base + chk_len;
  assign in_range = (chk_base >= cfg.app_start_address) && (chk_top <= cfg.flash_end_address);

  assign len_clamp = (32'(req.transfer_length) > TS_32) ? TS_LEN : LEN_W'(req.transfer_length);

  always_comb begin
    state_next           = state;
    latched_block_next   = latched_block;
    latched_length_next  = latched_length;
    latched_command_next = latched_command;
    latched_word_next    = latched_word;
    addr_ptr_next        = addr_ptr;
    res0         = '0;
    res1         = '0;
    flash_second = 1'b0;

    case (req.mode)
      dfu_req_pkg::MODE_DETACH: begin
        state_next       = dfu_req_pkg::ST_MANIFEST;
        res0.result_kind = dfu_req_pkg::KIND_ACK;
        res0.state_code  = dfu_req_pkg::state_code(state_next);
      end
      dfu_req_pkg::MODE_DOWNLOAD: begin
        if (req.transfer_length == 16'd0) begin
          state_next = dfu_req_pkg::ST_MAN_SYNC;
        end else begin
          latched_block_next   = req.block_number;
          latched_length_next  = len_clamp;
          latched_command_next = req.command_byte;
          // Payload bytes past the request length keep their old value.
          for (int i = 0; i < 4; i++) begin
            if (32'(len_clamp) > 32'(i + 1)) begin
              latched_word_next[8*i +: 8] = req.payload_word[8*i +: 8];
            end
          end
          state_next = dfu_req_pkg::ST_DN_SYNC;
        end
        res0.result_kind = dfu_req_pkg::KIND_ACK;
        res0.state_code  = dfu_req_pkg::state_code(state_next);
      end
      dfu_req_pkg::MODE_UPLOAD: begin
        state_next = dfu_req_pkg::ST_UP_IDLE;
        if (req.block_number == 16'd0) begin
          res0.result_kind  = dfu_req_pkg::KIND_CMD_LIST;
          res0.reply_length = dfu_req_pkg::LEN_CMD_LIST;
        end else if (cfg.upload_enable && in_range) begin
          res0.result_kind   = dfu_req_pkg::KIND_READ;
          res0.reply_length  = TS_11;
          res0.flash_address = base;
          res0.flash_length  = TS_11;
        end else begin
          state_next       = dfu_req_pkg::ST_ERROR;
          res0.result_kind = dfu_req_pkg::KIND_ACK;
        end
        res0.state_code = dfu_req_pkg::state_code(state_next);
      end
      dfu_req_pkg::MODE_GETSTATUS: begin
        res0.result_kind  = dfu_req_pkg::KIND_STATUS;
        res0.reply_length = dfu_req_pkg::LEN_STATUS;
        if (state == dfu_req_pkg::ST_DN_SYNC) begin
          // Reports busy, then runs the deferred action and lands in
          // download-idle within the same request.
          res0.poll_timeout = dfu_req_pkg::BUSY_POLL_MS;
          res0.state_code   = dfu_req_pkg::CODE_DN_BUSY;
          state_next        = dfu_req_pkg::ST_DN_IDLE;
          res1.state_code   = dfu_req_pkg::CODE_DN_IDLE;
          if (latched_block == 16'd0) begin
            if (latched_command == dfu_req_pkg::CMD_ERASE_PAGE) begin
              flash_second       = in_range;
              res1.result_kind   = dfu_req_pkg::KIND_ERASE;
              res1.flash_address = latched_word;
              res1.flash_length  = TS_11;
            end else if (latched_command == dfu_req_pkg::CMD_SET_ADDRESS) begin
              addr_ptr_next = latched_word;
            end
          end else begin
            flash_second       = in_range;
            res1.result_kind   = dfu_req_pkg::KIND_PROGRAM;
            res1.flash_address = base;
            res1.flash_length  = 11'(latched_length);
          end
        end else if (state == dfu_req_pkg::ST_MAN_SYNC) begin
          state_next      = dfu_req_pkg::ST_MANIFEST;
          res0.state_code = dfu_req_pkg::CODE_MANIFEST;
        end else if (state == dfu_req_pkg::ST_ERROR) begin
          res0.status_code = dfu_req_pkg::STATUS_ERROR;
          res0.state_code  = dfu_req_pkg::CODE_ERROR;
        end else begin
          res0.state_code = dfu_req_pkg::state_code(state);
        end
      end
      dfu_req_pkg::MODE_CLRSTATUS: begin
        if (state == dfu_req_pkg::ST_ERROR) begin
          state_next = dfu_req_pkg::ST_IDLE;
        end
        res0.result_kind = dfu_req_pkg::KIND_ACK;
        res0.state_code  = dfu_req_pkg::state_code(state_next);
      end
      dfu_req_pkg::MODE_GETSTATE: begin
        res0.result_kind  = dfu_req_pkg::KIND_STATE;
        res0.reply_length = dfu_req_pkg::LEN_STATE;
        res0.state_code   = dfu_req_pkg::state_code(state);
      end
      dfu_req_pkg::MODE_ABORT: begin
        state_next       = dfu_req_pkg::ST_IDLE;
        res0.result_kind = dfu_req_pkg::KIND_ACK;
        res0.state_code  = dfu_req_pkg::state_code(state_next);
      end
      default: begin
        res0.result_kind = dfu_req_pkg::KIND_UNHANDLED;
        res0.state_code  = dfu_req_pkg::state_code(state);
      end
    endcase

    // Ending in manifest always asks for a device reset. No flash action
    // can coincide, since those leave the state in download-idle.
    if (state_next == dfu_req_pkg::ST_MANIFEST) begin
      res1             = '0;
      res1.result_kind = dfu_req_pkg::KIND_RESET;
      res1.state_code  = dfu_req_pkg::CODE_MANIFEST;
      has_second       = 1'b1;
    end else begin
      has_second = flash_second;
    end
    res1.last = 1'b1;
    res0.last = !has_second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dfu_req_pkg::ST_IDLE;
      latched_block   <= '0;
      latched_length  <= '0;
      latched_command <= '0;
      latched_word    <= '0;
      addr_ptr        <= '0;
    end else if (commit) begin
      state           <= state_next;
      latched_block   <= latched_block_next;
      latched_length  <= latched_length_next;
      latched_command <= latched_command_next;
      latched_word    <= latched_word_next;
      addr_ptr        <= addr_ptr_next;
    end
  end

endmodule

@@ src/dfu_req_outbuf.sv @@
// Two-entry result register: the word on the output plus one pending word.
// Depends on dfu_req_pkg for the result and control types.
module dfu_req_outbuf (
  input  logic                     clk,
  input  logic                     rst,
  input  dfu_req_pkg::buf_ctl_t    ctl,
  input  dfu_req_pkg::result_t     res0,
  input  dfu_req_pkg::result_t     res1,
  output logic                     free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dfu_req_pkg::result_t     out_word
);

  dfu_req_pkg::result_t slot1;
  logic                 slot1_valid;
  logic                 pop;

  assign pop  = out_valid && out_ready;
  // Room for a new pair once nothing would remain after this cycle.
  assign free = !out_valid || (pop && !slot1_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      slot1_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid   <= 1'b1;
      slot1_valid <= ctl.has_second;
    end else if (pop) begin
      out_valid   <= slot1_valid;
      slot1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_word <= res0;
      slot1    <= res1;
    end else if (pop && slot1_valid) begin
      out_word <= slot1;
    end
  end

endmodule

@@ src/dfu_request_engine.sv @@
// A request is registered on acceptance; its first result word is registered in the output
// buffer when the request commits, which waits until the buffer has room.
// Throughput: one request per cycle when each causes one result word and the receiver does
// not stall; a request with two result words holds the single output port for both.
// Reset (rst, synchronous): DFU state idle, latched download and address
// pointer zero, configuration registers back to their defaults, no words held.
module dfu_request_engine #(
  parameter int TRANSFER_SIZE = dfu_req_pkg::TRANSFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] block_number,
  input  logic [15:0] transfer_length,
  input  logic [7:0]  command_byte,
  input  logic [31:0] payload_word,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  result_kind,
  output logic [10:0] reply_length,
  output logic [7:0]  status_code,
  output logic [23:0] poll_timeout,
  output logic [3:0]  state_code,
  output logic [31:0] flash_address,
  output logic [10:0] flash_length,
  output logic        last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dfu_req_pkg::cfg_t     cfg;
  dfu_req_pkg::req_t     req;
  logic                  req_valid;
  dfu_req_pkg::result_t  res0, res1, out_word;
  dfu_req_pkg::buf_ctl_t ctl;
  logic                  has_second;
  logic                  buf_free;

  // Configuration registers take a write in any cycle. Writes to an index
  // past the register list are accepted and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.app_start_address <= dfu_req_pkg::APP_START_RESET;
      cfg.flash_end_address <= dfu_req_pkg::FLASH_END_RESET;
      cfg.upload_enable     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfu_req_pkg::CFG_APP_START: cfg.app_start_address <= cfg_data;
        dfu_req_pkg::CFG_FLASH_END: cfg.flash_end_address <= cfg_data;
        dfu_req_pkg::CFG_UPLOAD_EN: cfg.upload_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The request register holds one word. It commits, updating the DFU
  // state and loading its results, once the result buffer will be empty
  // after this cycle; it takes the next word in the same cycle it commits.
  assign ctl.commit     = req_valid && buf_free;
  assign ctl.has_second = has_second;
  assign in_ready       = !req_valid || ctl.commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.mode            <= mode;
      req.block_number    <= block_number;
      req.transfer_length <= transfer_length;
      req.command_byte    <= command_byte;
      req.payload_word    <= payload_word;
    end
  end

  dfu_req_core #(
    .TRANSFER_SIZE(TRANSFER_SIZE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .commit     (ctl.commit),
    .cfg        (cfg),
    .res0       (res0),
    .res1       (res1),
    .has_second (has_second)
  );

  dfu_req_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res0      (res0),
    .res1      (res1),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign result_kind   = out_word.result_kind;
  assign reply_length  = out_word.reply_length;
  assign status_code   = out_word.status_code;
  assign poll_timeout  = out_word.poll_timeout;
  assign state_code    = out_word.state_code;
  assign flash_address = out_word.flash_address;
  assign flash_length  = out_word.flash_length;
  assign last          = out_word.last;

endmodule

@@ bench/tb_dfu_request_engine.sv @@
// Self-checking bench for dfu_request_engine: a short directed request list, then random DFU
// sessions under several flash windows, every result word checked against a local model.
// Depends on src/dfu_req_pkg.sv (codes, types) and src/dfu_request_engine.sv.
module tb_dfu_request_engine;

  localparam int          XFER_BYTES  = dfu_req_pkg::TRANSFER_SIZE_DEF;
  localparam logic [31:0] XFER        = XFER_BYTES;
  // A block-zero command byte that the engine does not know.
  localparam logic [7:0]  CMD_UNKNOWN = 8'h5A;
  // Cycles a phase may take to drain before we call it hung.
  localparam int          DRAIN_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  dfu_req_pkg::req_t offered = '0;
  logic [2:0]        mode;
  logic [15:0]       block_number;
  logic [15:0]       transfer_length;
  logic [7:0]        command_byte;
  logic [31:0]       payload_word;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  result_kind;
  logic [10:0] reply_length;
  logic [7:0]  status_code;
  logic [23:0] poll_timeout;
  logic [3:0]  reported_state;
  logic [31:0] flash_address;
  logic [10:0] flash_length;
  logic        last;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // The request word on the bus is whatever the driver currently offers.
  assign {mode, block_number, transfer_length, command_byte, payload_word} = offered;

  dfu_request_engine #(.TRANSFER_SIZE(XFER_BYTES)) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .block_number    (block_number),
    .transfer_length (transfer_length),
    .command_byte    (command_byte),
    .payload_word    (payload_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .reply_length    (reply_length),
    .status_code     (status_code),
    .poll_timeout    (poll_timeout),
    .state_code      (reported_state),
    .flash_address   (flash_address),
    .flash_length    (flash_length),
    .last            (last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be offered, and result words the engine still owes us.
  dfu_req_pkg::req_t    pending_requests[$];
  dfu_req_pkg::result_t expected_results[$];

  // Percent of cycles in which the sender idles or the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  // While nonzero the receiver refuses every word; counts down once per cycle.
  int hold_left = 0;

  int queued = 0;
  int requests_taken = 0;
  int words_seen = 0;
  int mismatches = 0;
  int register_writes = 0;
  int kind_seen[16];

  // Local copy of the engine: configuration, DFU state and the latched download.
  logic [31:0] app_start = dfu_req_pkg::APP_START_RESET;
  logic [31:0] flash_end = dfu_req_pkg::FLASH_END_RESET;
  logic        upload_on = 1'b0;
  logic [3:0]  dfu_code = dfu_req_pkg::CODE_IDLE;
  logic [15:0] held_block = '0;
  logic [10:0] held_length = '0;
  logic [7:0]  held_command = '0;
  logic [31:0] held_word = '0;
  logic [31:0] addr_pointer = '0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic dfu_req_pkg::result_t make_word(logic [3:0] kind, logic [10:0] rlen,
                                                     logic [7:0] status, logic [23:0] poll,
                                                     logic [31:0] addr, logic [10:0] flen);
    dfu_req_pkg::result_t w;
    w.result_kind   = kind;
    w.reply_length  = rlen;
    w.status_code   = status;
    w.poll_timeout  = poll;
    w.state_code    = dfu_code;
    w.flash_address = addr;
    w.flash_length  = flen;
    w.last          = 1'b0;
    return w;
  endfunction

  // A flash access is allowed when it starts at or above the application start and its
  // 32-bit wrapped end does not pass the end of flash.
  function automatic logic fits_flash(logic [31:0] base, logic [31:0] len);
    logic [31:0] top;
    top = base + len;
    return (base >= app_start) && (top <= flash_end);
  endfunction

  // Block two sits at the address pointer; every block is one transfer further on.
  function automatic logic [31:0] block_address(logic [15:0] blk);
    logic [31:0] offset;
    offset = ({16'd0, blk} - 32'd2) * XFER;
    return addr_pointer + offset;
  endfunction

  // Works out the result words of one accepted request and moves the model state on.
  task automatic predict_request(input dfu_req_pkg::req_t r);
    dfu_req_pkg::result_t fresh[$];
    logic [7:0]           status;
    logic [23:0]          poll;
    logic [31:0]          base;
    case (r.mode)
      dfu_req_pkg::MODE_DETACH: begin
        dfu_code = dfu_req_pkg::CODE_MANIFEST;
        fresh.push_back(make_word(dfu_req_pkg::KIND_ACK, '0, '0, '0, '0, '0));
      end
      dfu_req_pkg::MODE_DOWNLOAD: begin
        if (r.transfer_length == 16'd0) begin
          // A zero-length download is the request to leave and manifest.
          dfu_code = dfu_req_pkg::CODE_MAN_SYNC;
        end else begin
          held_block   = r.block_number;
          held_length  = (r.transfer_length > XFER[15:0]) ? XFER[10:0]
                                                            : r.transfer_length[10:0];
          held_command = r.command_byte;
          // Payload bytes past the transfer length keep their earlier value.
          for (int i = 0; i < 4; i++) begin
            if (i + 1 < held_length) held_word[8*i +: 8] = r.payload_word[8*i +: 8];
          end
          dfu_code = dfu_req_pkg::CODE_DN_SYNC;
        end
        fresh.push_back(make_word(dfu_req_pkg::KIND_ACK, '0, '0, '0, '0, '0));
      end
      dfu_req_pkg::MODE_UPLOAD: begin
        dfu_code = dfu_req_pkg::CODE_UP_IDLE;
        if (r.block_number == 16'd0) begin
          fresh.push_back(make_word(dfu_req_pkg::KIND_CMD_LIST, dfu_req_pkg::LEN_CMD_LIST,
                                    '0, '0, '0, '0));
        end else begin
          base = block_address(r.block_number);
          if (upload_on && fits_flash(base, XFER)) begin
            fresh.push_back(make_word(dfu_req_pkg::KIND_READ, XFER[10:0], '0, '0, base,
                                      XFER[10:0]));
          end else begin
            dfu_code = dfu_req_pkg::CODE_ERROR;
            fresh.push_back(make_word(dfu_req_pkg::KIND_ACK, '0, '0, '0, '0, '0));
          end
        end
      end
      dfu_req_pkg::MODE_GETSTATUS: begin
        status = '0;
        poll   = '0;
        if (dfu_code == dfu_req_pkg::CODE_DN_SYNC) begin
          dfu_code = dfu_req_pkg::CODE_DN_BUSY;
          poll     = dfu_req_pkg::BUSY_POLL_MS;
        end else if (dfu_code == dfu_req_pkg::CODE_MAN_SYNC) begin
          dfu_code = dfu_req_pkg::CODE_MANIFEST;
        end else if (dfu_code == dfu_req_pkg::CODE_ERROR) begin
          status = dfu_req_pkg::STATUS_ERROR;
        end
        fresh.push_back(make_word(dfu_req_pkg::KIND_STATUS, dfu_req_pkg::LEN_STATUS, status,
                                  poll, '0, '0));
        // The busy state lasts only for this request: the deferred flash action runs
        // and the engine settles in download-idle.
        if (dfu_code == dfu_req_pkg::CODE_DN_BUSY) begin
          dfu_code = dfu_req_pkg::CODE_DN_IDLE;
          if (held_block == 16'd0) begin
            if (held_command == dfu_req_pkg::CMD_ERASE_PAGE) begin
              if (fits_flash(held_word, XFER))
                fresh.push_back(make_word(dfu_req_pkg::KIND_ERASE, '0, '0, '0, held_word,
                                          XFER[10:0]));
            end else if (held_command == dfu_req_pkg::CMD_SET_ADDRESS) begin
              addr_pointer = held_word;
            end
          end else begin
            base = block_address(held_block);
            if (fits_flash(base, {21'd0, held_length}))
              fresh.push_back(make_word(dfu_req_pkg::KIND_PROGRAM, '0, '0, '0, base,
                                        held_length));
          end
        end
      end
      dfu_req_pkg::MODE_CLRSTATUS: begin
        if (dfu_code == dfu_req_pkg::CODE_ERROR) dfu_code = dfu_req_pkg::CODE_IDLE;
        fresh.push_back(make_word(dfu_req_pkg::KIND_ACK, '0, '0, '0, '0, '0));
      end
      dfu_req_pkg::MODE_GETSTATE: begin
        fresh.push_back(make_word(dfu_req_pkg::KIND_STATE, dfu_req_pkg::LEN_STATE,
                                  '0, '0, '0, '0));
      end
      dfu_req_pkg::MODE_ABORT: begin
        dfu_code = dfu_req_pkg::CODE_IDLE;
        fresh.push_back(make_word(dfu_req_pkg::KIND_ACK, '0, '0, '0, '0, '0));
      end
      default: begin
        fresh.push_back(make_word(dfu_req_pkg::KIND_UNHANDLED, '0, '0, '0, '0, '0));
      end
    endcase
    // Whenever a request leaves the engine in manifest, a reset request follows.
    if (dfu_code == dfu_req_pkg::CODE_MANIFEST && fresh.size() < 2)
      fresh.push_back(make_word(dfu_req_pkg::KIND_RESET, '0, '0, '0, '0, '0));
    fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[k]) expected_results.push_back(fresh[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s is 0x%0h, expected 0x%0h",
                                words_seen, name, got, want));
  endtask

  task automatic check_result_word();
    dfu_req_pkg::result_t want;
    words_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("word %0d of kind %0d arrived with nothing expected",
                                words_seen, result_kind));
    end else begin
      want = expected_results.pop_front();
      kind_seen[want.result_kind]++;
      check_field("result_kind", 32'(result_kind), 32'(want.result_kind));
      check_field("reply_length", 32'(reply_length), 32'(want.reply_length));
      check_field("status_code", 32'(status_code), 32'(want.status_code));
      check_field("poll_timeout", 32'(poll_timeout), 32'(want.poll_timeout));
      check_field("state_code", 32'(reported_state), 32'(want.state_code));
      check_field("flash_address", flash_address, want.flash_address);
      check_field("flash_length", 32'(flash_length), 32'(want.flash_length));
      check_field("last", 32'(last), 32'(want.last));
    end
  endtask

  // Request driver. The model is advanced at the edge that accepts a word, using the
  // payload that was on the bus at that edge; then the next word is offered or the
  // sender idles. A word once offered stays until taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(offered);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Checks each accepted word and picks the next ready at random,
  // or holds ready low for the whole of a long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result_word();
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // The long hold-off counts itself down here, one cycle at a time.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Writes one configuration register; the model takes the value at the accepting edge.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      dfu_req_pkg::CFG_APP_START: app_start = value;
      dfu_req_pkg::CFG_FLASH_END: flash_end = value;
      dfu_req_pkg::CFG_UPLOAD_EN: upload_on = value[0];
      default: ;
    endcase
    register_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_request(input logic [2:0] m, input logic [15:0] blk,
                             input logic [15:0] len, input logic [7:0] cmd,
                             input logic [31:0] word);
    dfu_req_pkg::req_t r;
    r.mode            = m;
    r.block_number    = blk;
    r.transfer_length = len;
    r.command_byte    = cmd;
    r.payload_word    = word;
    pending_requests.push_back(r);
    queued++;
  endtask

  // Requests whose other fields do not matter get random ones, which also toggles bits.
  task automatic add_plain(input logic [2:0] m);
    add_request(m, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
  endtask

  function automatic logic [31:0] pick_flash_address();
    case ($urandom_range(5))
      0, 1, 2: return app_start + XFER * $urandom_range(60);
      3:       return flash_end - XFER * $urandom_range(2);
      4:       return 32'hFFFF_FC00 | $urandom_range(1023);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_block();
    case ($urandom_range(5))
      0, 1, 2, 3: return 16'd2 + 16'($urandom_range(60));
      4:          return 16'($urandom);
      default:    return 16'($urandom_range(1));
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(6))
      0, 1, 2: return XFER[15:0];
      3:       return 16'($urandom_range(1, 8));
      4:       return 16'($urandom_range(1, XFER_BYTES));
      default: return 16'($urandom);
    endcase
  endfunction

  // One random session: mostly the request sequences a host really sends, with random
  // content, and now and then a broken sequence or plain noise.
  task automatic queue_session();
    int pick;
    int reps;
    pick = $urandom_range(99);
    reps = $urandom_range(1, 3);
    if (pick < 20) begin
      // Move the address pointer, sometimes with a short payload.
      add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0,
                  ($urandom_range(3) == 0) ? 16'($urandom_range(1, 8)) : 16'd5,
                  dfu_req_pkg::CMD_SET_ADDRESS, pick_flash_address());
      add_plain(dfu_req_pkg::MODE_GETSTATUS);
      if ($urandom_range(1) == 0) add_plain(dfu_req_pkg::MODE_GETSTATE);
    end else if (pick < 35) begin
      add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0,
                  ($urandom_range(3) == 0) ? 16'($urandom_range(1, 8)) : 16'd5,
                  dfu_req_pkg::CMD_ERASE_PAGE, pick_flash_address());
      add_plain(dfu_req_pkg::MODE_GETSTATUS);
    end else if (pick < 60) begin
      // Program blocks; a missing status poll leaves the engine in download-sync.
      for (int i = 0; i < reps; i++) begin
        add_request(dfu_req_pkg::MODE_DOWNLOAD, pick_block(), pick_length(),
                    8'($urandom), $urandom);
        if ($urandom_range(9) != 0) add_plain(dfu_req_pkg::MODE_GETSTATUS);
        if ($urandom_range(2) == 0) add_plain(dfu_req_pkg::MODE_GETSTATUS);
      end
    end else if (pick < 75) begin
      for (int i = 0; i < reps; i++)
        add_request(dfu_req_pkg::MODE_UPLOAD, pick_block(), 16'($urandom), 8'($urandom),
                    $urandom);
      case ($urandom_range(2))
        0:       add_plain(dfu_req_pkg::MODE_GETSTATUS);
        1:       add_plain(dfu_req_pkg::MODE_CLRSTATUS);
        default: add_plain(dfu_req_pkg::MODE_ABORT);
      endcase
    end else if (pick < 83) begin
      // Leave: zero-length download, status into manifest, then abort.
      add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'($urandom), 16'd0, 8'($urandom), $urandom);
      add_plain(dfu_req_pkg::MODE_GETSTATUS);
      if ($urandom_range(1) == 0) add_plain(dfu_req_pkg::MODE_GETSTATUS);
      add_plain(dfu_req_pkg::MODE_ABORT);
    end else if (pick < 88) begin
      add_plain(dfu_req_pkg::MODE_DETACH);
      add_plain(dfu_req_pkg::MODE_GETSTATE);
      add_plain(dfu_req_pkg::MODE_ABORT);
    end else if (pick < 93) begin
      add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0, 16'($urandom_range(1, 16)),
                  8'($urandom), $urandom);
      add_plain(dfu_req_pkg::MODE_GETSTATUS);
    end else begin
      for (int i = 0; i < reps; i++) add_plain(3'($urandom_range(7)));
    end
  endtask

  // Waits until every queued request is taken and every expected word has come,
  // then lets the engine's latency pass.
  task automatic drain_phase();
    int waited;
    waited = 0;
    while ((pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      report_mismatch($sformatf("stuck with %0d requests queued and %0d words owed",
                                pending_requests.size(), expected_results.size()));
      pending_requests.delete();
      expected_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] app, input logic [31:0] top, input logic up,
                           input int idle, input int stall, input int items,
                           input int hold);
    int target;
    write_register(dfu_req_pkg::CFG_APP_START, app);
    write_register(dfu_req_pkg::CFG_FLASH_END, top);
    write_register(dfu_req_pkg::CFG_UPLOAD_EN, {31'd0, up});
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    target    = queued + items;
    while (queued < target) queue_session();
    if (hold > 0) begin
      @(posedge clk);
      hold_left <= hold;
    end
    drain_phase();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed list under the reset window, upload disabled, no idling.
    add_plain(dfu_req_pkg::MODE_GETSTATE);
    add_request(dfu_req_pkg::MODE_UPLOAD, 16'd0, 16'd3, 8'h00, 32'h0);
    // Upload is refused while disabled, which lands in the error state.
    add_request(dfu_req_pkg::MODE_UPLOAD, 16'd2, XFER[15:0], 8'h00, 32'h0);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    add_plain(dfu_req_pkg::MODE_CLRSTATUS);
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0, 16'd5, dfu_req_pkg::CMD_SET_ADDRESS,
                dfu_req_pkg::APP_START_RESET);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    // Oversize download of block two: length clamps to one transfer.
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd2, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    // Erase of the last page in range, then one just below the window.
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0, 16'd5, dfu_req_pkg::CMD_ERASE_PAGE,
                dfu_req_pkg::FLASH_END_RESET - XFER);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0, 16'd5, dfu_req_pkg::CMD_ERASE_PAGE,
                dfu_req_pkg::APP_START_RESET - XFER);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    // Short payload: only the two low address bytes change, which brings it in range.
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0, 16'd3, dfu_req_pkg::CMD_ERASE_PAGE,
                32'hFFFF_F000);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd0, 16'd1, CMD_UNKNOWN, 32'h0);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    // The top block number lands far outside the window, so programming is skipped.
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'hFFFF, 16'd16, 8'h00, 32'h0);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    add_plain(dfu_req_pkg::MODE_DETACH);
    add_plain(dfu_req_pkg::MODE_GETSTATE);
    add_plain(dfu_req_pkg::MODE_OTHER);
    add_plain(dfu_req_pkg::MODE_ABORT);
    add_request(dfu_req_pkg::MODE_DOWNLOAD, 16'd7, 16'd0, 8'h00, 32'h0);
    add_plain(dfu_req_pkg::MODE_GETSTATUS);
    add_plain(dfu_req_pkg::MODE_ABORT);
    drain_phase();

    // Random sessions over several windows, from steady flow to heavy idling.
    run_phase(dfu_req_pkg::APP_START_RESET, dfu_req_pkg::FLASH_END_RESET, 1'b1, 0, 0, 90, 0);
    run_phase(32'h0, 32'hFFFF_FFFF, 1'b1, 57, 0, 80, 0);
    run_phase(32'h0800_0000, 32'h0802_0000, 1'b1, 0, 57, 80, 0);
    run_phase(32'hFFFF_FFFF, 32'h0, 1'b0, 34, 34, 40, 0);
    // The receiver holds off long enough for the engine to fill and stall its input.
    run_phase(dfu_req_pkg::APP_START_RESET, dfu_req_pkg::FLASH_END_RESET, 1'b1, 34, 34, 90,
              300);

    repeat (8) @(posedge clk);
    $display("Covered %0d requests, %0d result words and %0d register writes.",
             requests_taken, words_seen, register_writes);
    $display("Flash actions seen: %0d erase, %0d program, %0d read; %0d reset requests.",
             kind_seen[dfu_req_pkg::KIND_ERASE], kind_seen[dfu_req_pkg::KIND_PROGRAM],
             kind_seen[dfu_req_pkg::KIND_READ], kind_seen[dfu_req_pkg::KIND_RESET]);
    if (mismatches == 0) begin
      $display("dfu_request_engine regression: pass");
    end else begin
      $display("dfu_request_engine regression: fail");
    end
    $finish;
  end

  // Safety net in case the engine hangs.
  initial begin
    #(12 * 500000);
    $display("dfu_request_engine regression: fail");
    $finish;
  end

endmodule
